// ===== rtl/rv32i_execute_unit_core_assert.svh =====
// Assertion macros shared by the execute unit RTL.
// Each macro expands to one labeled concurrent assertion on a clock and reset.
`ifndef RV32I_EXECUTE_UNIT_CORE_ASSERT_SVH
`define RV32I_EXECUTE_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EXU_ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("execute unit assertion failed");

// Next-cycle implication, disabled during reset.
`define EXU_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("execute unit assertion failed");

`endif

// ===== rtl/rv32i_exu_pkg.sv =====
// Package for the RV32I execute unit: operation codes, constants and the
// structs passed between the pipeline stages. No dependencies.
package rv32i_exu_pkg;

  localparam int unsigned XLEN    = 32;
  localparam int unsigned KIND_W  = 6;
  localparam int unsigned SHAMT_W = 5;

  localparam logic [XLEN-1:0] INST_BYTES = 32'd4;
  localparam logic [XLEN-1:0] BYTE_MASK  = 32'h0000_00ff;
  localparam logic [XLEN-1:0] HALF_MASK  = 32'h0000_ffff;
  localparam logic [XLEN-1:0] ALIGN_MASK = ~32'd1;

  // Operation codes as delivered by decode.
  typedef enum logic [KIND_W-1:0] {
    K_ADD, K_SUB, K_SLL, K_SLT, K_SLTU, K_XOR, K_SRL, K_SRA, K_OR, K_AND,
    K_JALR,
    K_LB, K_LH, K_LW, K_LBU, K_LHU,
    K_ADDI, K_SLTI, K_SLTIU, K_XORI, K_ORI, K_ANDI, K_SLLI, K_SRAI, K_SRLI,
    K_SB, K_SH, K_SW,
    K_BEQ, K_BNE, K_BLT, K_BGE, K_BLTU, K_BGEU,
    K_LUI, K_AUIPC, K_JAL, K_INVALID
  } kind_t;

  // One decoded instruction as held in the input register.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [XLEN-1:0]   src_a;
    logic [XLEN-1:0]   src_b;
    logic [XLEN-1:0]   imm_value;
    logic [XLEN-1:0]   inst_addr;
    logic              guess_taken;
  } issue_t;

  // Data path results of the ALU.
  typedef struct packed {
    logic [XLEN-1:0] alu_out;
    logic [XLEN-1:0] mem_addr;
  } alu_res_t;

  // Control flow results of the branch unit.
  typedef struct packed {
    logic [XLEN-1:0] next_addr;
    logic            took_branch;
    logic            wrong_guess;
  } redirect_t;

endpackage

// ===== rtl/rv32i_exu_if.sv =====
// Valid/ready channel interfaces for the execute unit's input and output beats.
// Depends on rv32i_exu_pkg for widths.
interface rv32i_exu_in_if;
  import rv32i_exu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [XLEN-1:0]   src_a;
  logic signed [XLEN-1:0]   src_b;
  logic signed [XLEN-1:0]   imm_value;
  logic [XLEN-1:0]          inst_addr;
  logic                     guess_taken;

  modport source (output valid, kind, src_a, src_b, imm_value, inst_addr, guess_taken,
                  input ready);
  modport sink (input valid, kind, src_a, src_b, imm_value, inst_addr, guess_taken,
                output ready);
endinterface

interface rv32i_exu_out_if;
  import rv32i_exu_pkg::*;

  logic            valid;
  logic            ready;
  logic [XLEN-1:0] alu_out;
  logic [XLEN-1:0] mem_addr;
  logic [XLEN-1:0] next_addr;
  logic            took_branch;
  logic            wrong_guess;

  modport source (output valid, alu_out, mem_addr, next_addr, took_branch, wrong_guess,
                  input ready);
  modport sink (input valid, alu_out, mem_addr, next_addr, took_branch, wrong_guess,
                output ready);
endinterface

// ===== rtl/rv32i_exu_alu.sv =====
// Arithmetic and logic part of the execute unit: ALU result, link value,
// store data and effective address. Depends on rv32i_exu_pkg.
module rv32i_exu_alu (
  input  rv32i_exu_pkg::issue_t   op,
  output rv32i_exu_pkg::alu_res_t res
);
  import rv32i_exu_pkg::*;

  logic              use_imm;
  logic [XLEN-1:0]   opnd_b;
  logic [SHAMT_W-1:0] shamt;
  logic [XLEN-1:0]   sum;
  logic [XLEN-1:0]   diff;
  logic [XLEN-1:0]   addr_sum;
  logic              lt_s;
  logic              lt_u;
  logic              is_mem;

  // Second operand is the immediate for register-immediate operations.
  assign use_imm  = op.kind inside {[K_ADDI:K_SRLI]};
  assign opnd_b   = use_imm ? op.imm_value : op.src_b;
  assign shamt    = opnd_b[SHAMT_W-1:0];
  assign sum      = op.src_a + opnd_b;
  assign diff     = op.src_a - op.src_b;
  assign addr_sum = op.src_a + op.imm_value;
  assign lt_s     = $signed(op.src_a) < $signed(opnd_b);
  assign lt_u     = op.src_a < opnd_b;
  assign is_mem   = op.kind inside {[K_LB:K_LHU], [K_SB:K_SW]};

  // Result select by operation.
  always_comb begin
    case (op.kind)
      K_ADD, K_ADDI:   res.alu_out = sum;
      K_SUB:           res.alu_out = diff;
      K_SLL, K_SLLI:   res.alu_out = op.src_a << shamt;
      K_SLT, K_SLTI:   res.alu_out = {{(XLEN-1){1'b0}}, lt_s};
      K_SLTU, K_SLTIU: res.alu_out = {{(XLEN-1){1'b0}}, lt_u};
      K_XOR, K_XORI:   res.alu_out = op.src_a ^ opnd_b;
      K_SRL, K_SRLI:   res.alu_out = op.src_a >> shamt;
      K_SRA, K_SRAI:   res.alu_out = $unsigned($signed(op.src_a) >>> shamt);
      K_OR, K_ORI:     res.alu_out = op.src_a | opnd_b;
      K_AND, K_ANDI:   res.alu_out = op.src_a & opnd_b;
      K_JALR, K_JAL:   res.alu_out = op.inst_addr + INST_BYTES;
      K_SB:            res.alu_out = op.src_b & BYTE_MASK;
      K_SH:            res.alu_out = op.src_b & HALF_MASK;
      K_SW:            res.alu_out = op.src_b;
      K_LUI:           res.alu_out = op.imm_value;
      K_AUIPC:         res.alu_out = op.inst_addr + op.imm_value;
      default:         res.alu_out = '0;
    endcase
  end

  // Effective address only for loads and stores.
  assign res.mem_addr = is_mem ? addr_sum : '0;

endmodule

// ===== rtl/rv32i_exu_branch.sv =====
// Branch and jump resolution: next address, taken flag and mispredict flag.
// Depends on rv32i_exu_pkg.
module rv32i_exu_branch (
  input  rv32i_exu_pkg::issue_t    op,
  output rv32i_exu_pkg::redirect_t redir
);
  import rv32i_exu_pkg::*;

  logic            eq;
  logic            lt_s;
  logic            lt_u;
  logic            cond;
  logic            is_branch;
  logic [XLEN-1:0] seq_addr;
  logic [XLEN-1:0] rel_addr;
  logic [XLEN-1:0] reg_addr;

  assign eq        = op.src_a == op.src_b;
  assign lt_s      = $signed(op.src_a) < $signed(op.src_b);
  assign lt_u      = op.src_a < op.src_b;
  assign is_branch = op.kind inside {[K_BEQ:K_BGEU]};
  assign seq_addr  = op.inst_addr + INST_BYTES;
  assign rel_addr  = op.inst_addr + op.imm_value;
  assign reg_addr  = (op.src_a + op.imm_value) & ALIGN_MASK;

  // Branch condition by comparison type.
  always_comb begin
    case (op.kind)
      K_BEQ:   cond = eq;
      K_BNE:   cond = !eq;
      K_BLT:   cond = lt_s;
      K_BGE:   cond = !lt_s;
      K_BLTU:  cond = lt_u;
      K_BGEU:  cond = !lt_u;
      default: cond = 1'b0;
    endcase
  end

  // Next address and flags; jumps are always taken and never mispredicted.
  always_comb begin
    case (op.kind)
      K_JAL: begin
        redir.next_addr   = rel_addr;
        redir.took_branch = 1'b1;
      end
      K_JALR: begin
        redir.next_addr   = reg_addr;
        redir.took_branch = 1'b1;
      end
      default: begin
        redir.next_addr   = cond ? rel_addr : seq_addr;
        redir.took_branch = cond;
      end
    endcase
    redir.wrong_guess = is_branch && (cond != op.guess_taken);
  end

endmodule

// ===== rtl/rv32i_execute_unit_core.sv =====
// RV32I execute unit: input register, ALU and branch logic, result register.
// An accepted beat passes through the input register and then the result register.
// Throughput: one instruction per cycle while results are taken (two register stages).
// A full, untaken result register stalls, as does the input register if it is full.
// Reset (rst, synchronous, active high) empties both stages; no other state.
module rv32i_execute_unit_core (
  input logic             clk,
  input logic             rst,
  rv32i_exu_in_if.sink    issue,
  rv32i_exu_out_if.source result
);
  import rv32i_exu_pkg::*;

  `include "rv32i_execute_unit_core_assert.svh"

  logic      s1_valid;
  issue_t    s1;
  logic      res_valid;
  alu_res_t  res_alu;
  redirect_t res_redir;
  alu_res_t  alu_res;
  redirect_t redir;
  logic      out_free;
  logic      s1_move;

  // Handshake: the result register frees when empty or taken this cycle.
  assign out_free    = !res_valid || result.ready;
  assign s1_move     = s1_valid && out_free;
  assign issue.ready = !s1_valid || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue.ready) begin
      s1_valid <= issue.valid;
    end
    if (issue.ready && issue.valid) begin
      s1.kind        <= issue.kind;
      s1.src_a       <= $unsigned(issue.src_a);
      s1.src_b       <= $unsigned(issue.src_b);
      s1.imm_value   <= $unsigned(issue.imm_value);
      s1.inst_addr   <= issue.inst_addr;
      s1.guess_taken <= issue.guess_taken;
    end
  end

  // Execute logic.
  rv32i_exu_alu u_alu (
    .op  (s1),
    .res (alu_res)
  );

  rv32i_exu_branch u_branch (
    .op    (s1),
    .redir (redir)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid;
    end
    if (s1_move) begin
      res_alu   <= alu_res;
      res_redir <= redir;
    end
  end

  assign result.valid       = res_valid;
  assign result.alu_out     = res_alu.alu_out;
  assign result.mem_addr    = res_alu.mem_addr;
  assign result.next_addr   = res_redir.next_addr;
  assign result.took_branch = res_redir.took_branch;
  assign result.wrong_guess = res_redir.wrong_guess;

  // An accepted beat lands in the input register.
  `EXU_ASSERT_NEXT(a_issue_lands, clk, rst, issue.valid && issue.ready, s1_valid)
  // A beat leaving the input register lands in the result register.
  `EXU_ASSERT_NEXT(a_s1_lands, clk, rst, s1_move, res_valid)
  // Jumps are always taken and never flagged as mispredicted.
  `EXU_ASSERT_SAME(a_jump_taken, clk, rst,
    s1_valid && (s1.kind == K_JAL || s1.kind == K_JALR),
    redir.took_branch && !redir.wrong_guess)
  // A nonzero effective address comes only from a load or a store.
  `EXU_ASSERT_SAME(a_addr_mem_only, clk, rst, s1_valid && alu_res.mem_addr != '0,
    (s1.kind >= K_LB && s1.kind <= K_LHU) || (s1.kind >= K_SB && s1.kind <= K_SW))

endmodule

// ===== tb/sv/rv32i_execute_unit_core_tb.sv =====
// Self-checking testbench for rv32i_execute_unit_core: directed table, then random beats.
// Every result is checked against its fixed table row or a local execute-stage predictor.
// Depends on rv32i_exu_pkg, the rv32i_exu_in_if/out_if interfaces and the core RTL.
module rv32i_execute_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rv32i_exu_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1925;
  localparam int TAIL_ITEMS   = 150;
  localparam int DRAIN_CYCLES = 10;
  localparam int LONG_HOLD    = 60;
  localparam int HOLD_SPACING = 500;
  localparam int HOLD_TOTAL   = 2;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 100;

  // Highest code the kind field can carry; everything past K_INVALID is unused.
  localparam logic [KIND_W-1:0] KIND_LAST = '1;

  // One result beat as seen on the output channel.
  typedef struct packed {
    logic [XLEN-1:0] alu_out;
    logic [XLEN-1:0] mem_addr;
    logic [XLEN-1:0] next_addr;
    logic            took_branch;
    logic            wrong_guess;
  } exu_result_t;

  // One row of the directed table; fixed rows carry their own expected result.
  typedef struct {
    issue_t      beat;
    bit          fixed;
    exu_result_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;

  rv32i_exu_in_if  issue_ch ();
  rv32i_exu_out_if result_ch ();

  rv32i_execute_unit_core dut (
    .clk    (clk),
    .rst    (rst),
    .issue  (issue_ch),
    .result (result_ch)
  );

  directed_row_t directed_rows[$];
  exu_result_t   pending_results[$];
  int            fail_count   = 0;
  int            results_seen = 0;
  int            cycle_count  = 0;
  bit            tail_phase   = 1'b0;
  bit            tx_idle_on   = 1'b0;

  // Clock: 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Expected outcome of one instruction in the execute stage.
  function automatic exu_result_t predict_execute(input issue_t beat);
    exu_result_t     r;
    logic [XLEN-1:0] a, b, imm, pc;
    logic [SHAMT_W-1:0] sh_b, sh_i;
    logic            cond;
    bit              is_branch;
    a    = beat.src_a;
    b    = beat.src_b;
    imm  = beat.imm_value;
    pc   = beat.inst_addr;
    sh_b = b[SHAMT_W-1:0];
    sh_i = imm[SHAMT_W-1:0];
    cond = 1'b0;
    is_branch = 1'b0;
    r.alu_out     = '0;
    r.mem_addr    = '0;
    r.next_addr   = pc + INST_BYTES;
    r.took_branch = 1'b0;
    r.wrong_guess = 1'b0;
    case (beat.kind)
      K_ADD:   r.alu_out = a + b;
      K_SUB:   r.alu_out = a - b;
      K_SLL:   r.alu_out = a << sh_b;
      K_SLT:   r.alu_out = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      K_SLTU:  r.alu_out = (a < b) ? 32'd1 : 32'd0;
      K_XOR:   r.alu_out = a ^ b;
      K_SRL:   r.alu_out = a >> sh_b;
      K_SRA:   r.alu_out = $signed(a) >>> sh_b;
      K_OR:    r.alu_out = a | b;
      K_AND:   r.alu_out = a & b;
      K_JALR: begin
        r.alu_out     = pc + INST_BYTES;
        r.next_addr   = (a + imm) & ALIGN_MASK;
        r.took_branch = 1'b1;
      end
      K_LB, K_LH, K_LW, K_LBU, K_LHU: r.mem_addr = a + imm;
      K_ADDI:  r.alu_out = a + imm;
      K_SLTI:  r.alu_out = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
      K_SLTIU: r.alu_out = (a < imm) ? 32'd1 : 32'd0;
      K_XORI:  r.alu_out = a ^ imm;
      K_ORI:   r.alu_out = a | imm;
      K_ANDI:  r.alu_out = a & imm;
      K_SLLI:  r.alu_out = a << sh_i;
      K_SRAI:  r.alu_out = $signed(a) >>> sh_i;
      K_SRLI:  r.alu_out = a >> sh_i;
      K_SB: begin
        r.alu_out  = b & BYTE_MASK;
        r.mem_addr = a + imm;
      end
      K_SH: begin
        r.alu_out  = b & HALF_MASK;
        r.mem_addr = a + imm;
      end
      K_SW: begin
        r.alu_out  = b;
        r.mem_addr = a + imm;
      end
      K_BEQ: begin
        cond = (a == b);
        is_branch = 1'b1;
      end
      K_BNE: begin
        cond = (a != b);
        is_branch = 1'b1;
      end
      K_BLT: begin
        cond = $signed(a) < $signed(b);
        is_branch = 1'b1;
      end
      K_BGE: begin
        cond = $signed(a) >= $signed(b);
        is_branch = 1'b1;
      end
      K_BLTU: begin
        cond = (a < b);
        is_branch = 1'b1;
      end
      K_BGEU: begin
        cond = (a >= b);
        is_branch = 1'b1;
      end
      K_LUI:   r.alu_out = imm;
      K_AUIPC: r.alu_out = pc + imm;
      K_JAL: begin
        r.alu_out     = pc + INST_BYTES;
        r.next_addr   = pc + imm;
        r.took_branch = 1'b1;
      end
      default: ;
    endcase
    // Conditional branches redirect only when taken and flag a wrong guess either way.
    if (is_branch) begin
      r.took_branch = cond;
      if (cond) begin
        r.next_addr = pc + imm;
      end
      r.wrong_guess = (cond != beat.guess_taken);
    end
    return r;
  endfunction

  // One line per mismatch, capped so a broken build cannot flood the log.
  task automatic report_mismatch(input string field, input logic [XLEN-1:0] got,
                                 input logic [XLEN-1:0] want);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("exu check: result %0d %s got %h expected %h", results_seen, field, got, want);
    end
  endtask

  // Compare the beat on the result channel with the oldest expectation.
  task automatic check_result();
    exu_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected beat, alu_out", result_ch.alu_out, '0);
    end else begin
      want = pending_results.pop_front();
      if (result_ch.alu_out !== want.alu_out)
        report_mismatch("alu_out", result_ch.alu_out, want.alu_out);
      if (result_ch.mem_addr !== want.mem_addr)
        report_mismatch("mem_addr", result_ch.mem_addr, want.mem_addr);
      if (result_ch.next_addr !== want.next_addr)
        report_mismatch("next_addr", result_ch.next_addr, want.next_addr);
      if (result_ch.took_branch !== want.took_branch)
        report_mismatch("took_branch", 32'(result_ch.took_branch), 32'(want.took_branch));
      if (result_ch.wrong_guess !== want.wrong_guess)
        report_mismatch("wrong_guess", 32'(result_ch.wrong_guess), 32'(want.wrong_guess));
    end
  endtask

  task automatic add_row(input bit fixed, input logic [KIND_W-1:0] kind,
                         input logic [XLEN-1:0] a, input logic [XLEN-1:0] b,
                         input logic [XLEN-1:0] imm, input logic [XLEN-1:0] pc,
                         input logic guess,
                         input logic [XLEN-1:0] alu, input logic [XLEN-1:0] mem,
                         input logic [XLEN-1:0] next, input logic took, input logic wrong);
    directed_row_t row;
    row.beat.kind        = kind;
    row.beat.src_a       = a;
    row.beat.src_b       = b;
    row.beat.imm_value   = imm;
    row.beat.inst_addr   = pc;
    row.beat.guess_taken = guess;
    row.fixed            = fixed;
    row.want.alu_out     = alu;
    row.want.mem_addr    = mem;
    row.want.next_addr   = next;
    row.want.took_branch = took;
    row.want.wrong_guess = wrong;
    directed_rows.push_back(row);
  endtask

  // Directed table: field extremes, wrap-around, shift limits, branches both ways,
  // jumps, store masking and unknown kinds. Rows with fixed = 0 use the predictor.
  task automatic build_directed_table();
    //      fixed kind       src_a         src_b         imm           inst_addr     g
    //      alu_out       mem_addr      next_addr     took wrong
    add_row(1, K_ADD,    32'h7fffffff, 32'h00000001, 32'h00000000, 32'h00000000, 0,
            32'h80000000, 32'h00000000, 32'h00000004, 0, 0);
    add_row(1, K_SUB,    32'h80000000, 32'h00000001, 32'h00000000, 32'h00000100, 0,
            32'h7fffffff, 32'h00000000, 32'h00000104, 0, 0);
    add_row(0, K_SLL,    32'h00000001, 32'hffffffff, 32'h00000000, 32'h00000200, 1,
            '0, '0, '0, 0, 0);
    add_row(1, K_SRL,    32'h80000000, 32'h0000001f, 32'h00000000, 32'h00000010, 0,
            32'h00000001, 32'h00000000, 32'h00000014, 0, 0);
    add_row(1, K_SRA,    32'h80000000, 32'h0000001f, 32'h00000000, 32'h00000010, 0,
            32'hffffffff, 32'h00000000, 32'h00000014, 0, 0);
    add_row(0, K_SRA,    32'h80000000, 32'h00000020, 32'h00000000, 32'h00000018, 1,
            '0, '0, '0, 0, 0);
    add_row(1, K_SLT,    32'h80000000, 32'h7fffffff, 32'h00000000, 32'h00000020, 0,
            32'h00000001, 32'h00000000, 32'h00000024, 0, 0);
    add_row(1, K_SLTU,   32'h80000000, 32'h7fffffff, 32'h00000000, 32'h00000020, 0,
            32'h00000000, 32'h00000000, 32'h00000024, 0, 0);
    add_row(0, K_AND,    32'hffffffff, 32'h12345678, 32'hffffffff, 32'h00000030, 1,
            '0, '0, '0, 0, 0);
    // JALR clears bit 0 of the target and wraps the link value.
    add_row(1, K_JALR,   32'hffffffff, 32'h00000000, 32'h00000002, 32'hfffffffc, 0,
            32'h00000000, 32'h00000000, 32'h00000000, 1, 0);
    add_row(1, K_LB,     32'hffffffff, 32'h00000000, 32'h00000001, 32'h00000040, 1,
            32'h00000000, 32'h00000000, 32'h00000044, 0, 0);
    add_row(1, K_SB,     32'h00000100, 32'hdeadbeef, 32'h00000010, 32'h00000050, 0,
            32'h000000ef, 32'h00000110, 32'h00000054, 0, 0);
    add_row(1, K_SH,     32'h00000100, 32'hdeadbeef, 32'h00000010, 32'h00000050, 0,
            32'h0000beef, 32'h00000110, 32'h00000054, 0, 0);
    add_row(0, K_SW,     32'hfffffff0, 32'hdeadbeef, 32'h00000020, 32'h00000058, 1,
            '0, '0, '0, 0, 0);
    // Branch taken against a not-taken guess, and not taken against a taken guess.
    add_row(1, K_BEQ,    32'h00000005, 32'h00000005, 32'h00000080, 32'h00001000, 0,
            32'h00000000, 32'h00000000, 32'h00001080, 1, 1);
    add_row(1, K_BNE,    32'h00000005, 32'h00000005, 32'h00000080, 32'h00001000, 1,
            32'h00000000, 32'h00000000, 32'h00001004, 0, 1);
    add_row(0, K_BLT,    32'h80000000, 32'h00000001, 32'hfffffff0, 32'h00002000, 1,
            '0, '0, '0, 0, 0);
    add_row(0, K_BGE,    32'h80000000, 32'h00000001, 32'hfffffff0, 32'h00002000, 0,
            '0, '0, '0, 0, 0);
    add_row(0, K_BLTU,   32'h80000000, 32'h00000001, 32'hfffffff0, 32'h00002000, 1,
            '0, '0, '0, 0, 0);
    add_row(0, K_BGEU,   32'h80000000, 32'h00000001, 32'hfffffff0, 32'h00002000, 0,
            '0, '0, '0, 0, 0);
    add_row(1, K_LUI,    32'h00000000, 32'h00000000, 32'hfffff000, 32'h00003000, 0,
            32'hfffff000, 32'h00000000, 32'h00003004, 0, 0);
    add_row(1, K_AUIPC,  32'h00000000, 32'h00000000, 32'h00001000, 32'hfffff000, 0,
            32'h00000000, 32'h00000000, 32'hfffff004, 0, 0);
    add_row(1, K_JAL,    32'h00000000, 32'h00000000, 32'h00000008, 32'hfffffffc, 1,
            32'h00000000, 32'h00000000, 32'h00000004, 1, 0);
    // Unknown kinds give zero data and sequential flow.
    add_row(1, K_INVALID, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1,
            32'h00000000, 32'h00000000, 32'h00000003, 0, 0);
    add_row(1, KIND_LAST, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h00000000, 1,
            32'h00000000, 32'h00000000, 32'h00000004, 0, 0);
  endtask

  // Operand values, biased toward the corners and small shift amounts.
  function automatic logic [XLEN-1:0] pick_word();
    logic [XLEN-1:0] w;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       w = 32'h00000000;
          1:       w = 32'h00000001;
          2:       w = 32'hffffffff;
          3:       w = 32'h7fffffff;
          default: w = 32'h80000000;
        endcase
      end
      1:       w = $urandom_range(0, 40);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic issue_t make_random_beat();
    issue_t beat;
    if ($urandom_range(0, 9) == 0)
      beat.kind = KIND_W'($urandom_range(int'(K_INVALID), int'(KIND_LAST)));
    else
      beat.kind = KIND_W'($urandom_range(int'(K_ADD), int'(K_JAL)));
    beat.src_a     = pick_word();
    beat.src_b     = pick_word();
    beat.imm_value = pick_word();
    if ($urandom_range(0, 7) == 0)
      beat.inst_addr = 32'hfffffff0 | $urandom_range(0, 15);
    else
      beat.inst_addr = $urandom;
    beat.guess_taken = 1'($urandom_range(0, 1));
    // Equal operands so that BEQ and BGE/BGEU hit their equality case often.
    if (beat.kind >= K_BEQ && beat.kind <= K_BGEU && $urandom_range(0, 2) == 0)
      beat.src_b = beat.src_a;
    return beat;
  endfunction

  // Offer one beat, with an optional idle burst before it, and record its expectation.
  task automatic offer_beat(input issue_t beat, input bit fixed, input exu_result_t want);
    int gap;
    if (!tail_phase && tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      issue_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    issue_ch.valid       <= 1'b1;
    issue_ch.kind        <= beat.kind;
    issue_ch.src_a       <= beat.src_a;
    issue_ch.src_b       <= beat.src_b;
    issue_ch.imm_value   <= beat.imm_value;
    issue_ch.inst_addr   <= beat.inst_addr;
    issue_ch.guess_taken <= beat.guess_taken;
    do @(posedge clk); while (!issue_ch.ready);
    pending_results.push_back(fixed ? want : predict_execute(beat));
  endtask

  // Stimulus and end of run.
  initial begin
    issue_t      beat;
    exu_result_t want;
    bit          fixed;
    int          total;
    rst                  <= 1'b1;
    issue_ch.valid       <= 1'b0;
    issue_ch.kind        <= '0;
    issue_ch.src_a       <= '0;
    issue_ch.src_b       <= '0;
    issue_ch.imm_value   <= '0;
    issue_ch.inst_addr   <= '0;
    issue_ch.guess_taken <= 1'b0;
    build_directed_table();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    total = directed_rows.size() + RANDOM_ITEMS;
    for (int idx = 0; idx < total; idx++) begin
      if (idx % 100 == 0)
        tx_idle_on = 1'($urandom_range(0, 1));
      tail_phase = (idx >= total - TAIL_ITEMS);
      if (idx < directed_rows.size()) begin
        beat  = directed_rows[idx].beat;
        fixed = directed_rows[idx].fixed;
        want  = directed_rows[idx].want;
      end else begin
        beat  = make_random_beat();
        fixed = 1'b0;
        want  = '0;
      end
      offer_beat(beat, fixed, want);
    end
    issue_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("rv32i_execute_unit_core: match");
    else
      $display("rv32i_execute_unit_core: mismatch");
    $finish;
  end

  // Result side: check each accepted beat, then choose ready for the next edge.
  // Stalls come in short random bursts, plus a few long hold-offs that back up the pipe.
  initial begin
    int rx_stall;
    int rx_cycles;
    int holds_done;
    bit rx_idle_on;
    rx_stall   = 0;
    rx_cycles  = 0;
    holds_done = 0;
    rx_idle_on = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        check_result();
        results_seen++;
      end
      if (rx_cycles % 128 == 0)
        rx_idle_on = 1'($urandom_range(0, 1));
      rx_cycles++;
      if (rx_stall == 0) begin
        if (holds_done < HOLD_TOTAL && results_seen >= (holds_done + 1) * HOLD_SPACING) begin
          rx_stall = LONG_HOLD;
          holds_done++;
        end else if (!tail_phase && rx_idle_on && $urandom_range(0, 3) == 0) begin
          rx_stall = $urandom_range(1, 4);
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("rv32i_execute_unit_core: mismatch");
    $finish;
  end

endmodule
